// ===== hdl/cpos_pkg.sv =====
`default_nettype none

package cpos_pkg;

    // vertex limit per polygon
    localparam int MAX_VERTS_DEF = 8;

    // coordinate, edge delta, product and projection widths
    localparam int COORD_W = 16;
    localparam int DELTA_W = COORD_W + 1;
    localparam int PROD_W  = DELTA_W + COORD_W;
    localparam int PROJ_W  = PROD_W + 1;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/cpos_ram.sv =====
`default_nettype none

module cpos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read, read data holds when idle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/convex_polygon_overlap_sat_core.sv =====
`default_nettype none

// Separating axis overlap test for two convex polygons with signed 16-bit
// integer vertices. Vertices come in one item per cycle while the block is
// idle, each tagged with its polygon, and are kept in arrival order in a
// single-port vertex RAM of 2*MAX_VERTS entries; a vertex for a polygon that
// is already full is dropped and flagged. The item with last_vertex set stores
// its vertex and starts the test, during which in_ready is low. For every edge
// of both polygons the normal (dy, -dx) is formed from two RAM reads, then
// every vertex of both polygons is projected on it exactly (dy*x - dx*y) with
// one shared 17x16 signed multiplier used twice per vertex, so each projection
// runs as RAM read, two multiplies, then subtract and min/max update. The test
// stops at the first separating axis. An overflow or empty polygon is reported
// without running the test. The result sits in an output register, and
// vertices for the next pair may be loaded while it waits to be taken.
// Touching intervals count as overlapping; an overflow status wins over an
// empty one and forces overlap 0.
module convex_polygon_overlap_sat_core #(
    parameter int MAX_VERTS = cpos_pkg::MAX_VERTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // vertex items
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                polygon_select,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] vertex_x,
    input  wire logic signed [cpos_pkg::COORD_W-1:0] vertex_y,
    input  wire logic                                last_vertex,
    // result items
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     overlap,
    output logic             [1:0]                   status
);

    localparam int DEPTH  = 2 * MAX_VERTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_VERTS);
    localparam int CNT_W  = $clog2(MAX_VERTS + 1);
    localparam int CW     = cpos_pkg::COORD_W;
    localparam int DW     = cpos_pkg::DELTA_W;
    localparam int PW     = cpos_pkg::PROD_W;
    localparam int JW     = cpos_pkg::PROJ_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EDGE_RD0,
        S_EDGE_RD1,
        S_EDGE_D,
        S_P_RD,
        S_P_M1,
        S_P_M2,
        S_P_UPD,
        S_CMP,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg [2];
    logic [CNT_W-1:0]        cnt_next [2];
    logic                    ovf_reg, ovf_next;
    logic                    edge_poly_reg, edge_poly_next;
    logic [IDX_W-1:0]        edge_idx_reg, edge_idx_next;
    logic                    proj_poly_reg, proj_poly_next;
    logic [IDX_W-1:0]        proj_idx_reg, proj_idx_next;
    logic signed [CW-1:0]    xi_reg, xi_next;
    logic signed [CW-1:0]    yi_reg, yi_next;
    logic signed [DW-1:0]    dx_reg, dx_next;
    logic signed [DW-1:0]    dy_reg, dy_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic signed [PW-1:0]    acc_reg, acc_next;
    logic signed [JW-1:0]    lo_reg [2];
    logic signed [JW-1:0]    lo_next [2];
    logic signed [JW-1:0]    hi_reg [2];
    logic signed [JW-1:0]    hi_next [2];
    logic                    pend_overlap_reg, pend_overlap_next;
    logic [1:0]              pend_status_reg, pend_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    overlap_reg, overlap_next;
    logic [1:0]              status_reg, status_next;

    // vertex RAM port
    logic                    ram_we;
    logic                    ram_re;
    logic                    addr_poly;
    logic [IDX_W-1:0]        addr_idx;
    logic [ADDR_W-1:0]       ram_addr;
    logic [2*CW-1:0]         ram_wdata;
    logic [2*CW-1:0]         ram_rdata;
    logic signed [CW-1:0]    rd_x;
    logic signed [CW-1:0]    rd_y;

    // shared multiplier
    logic signed [DW-1:0]    mul_a;
    logic signed [CW-1:0]    mul_b;
    logic signed [PW-1:0]    mul_res;

    // loop bookkeeping
    logic [CNT_W-1:0]        sel_cnt;
    logic [CNT_W-1:0]        edge_cnt;
    logic [CNT_W-1:0]        edge_inc;
    logic                    edge_wrap;
    logic [IDX_W-1:0]        edge_nxt_idx;
    logic [CNT_W-1:0]        proj_cnt;
    logic [CNT_W-1:0]        proj_inc;
    logic                    proj_last;
    logic signed [JW-1:0]    proj;
    logic                    separated;
    logic                    out_free;

    cpos_ram #(
        .WIDTH (2 * CW),
        .DEPTH (DEPTH)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // second polygon sits above the first in the RAM
    assign ram_addr  = addr_poly ? ADDR_W'(MAX_VERTS) + ADDR_W'(addr_idx) : ADDR_W'(addr_idx);
    assign ram_wdata = {vertex_y, vertex_x};
    assign rd_x      = ram_rdata[CW-1:0];
    assign rd_y      = ram_rdata[2*CW-1:CW];

    // first pass multiplies dy*x, second pass dx*y, both from the held read data
    assign mul_a   = (state_reg == S_P_M1) ? dy_reg : dx_reg;
    assign mul_b   = (state_reg == S_P_M1) ? rd_x : rd_y;
    assign mul_res = PW'(mul_a) * PW'(mul_b);

    assign sel_cnt      = polygon_select ? cnt_reg[1] : cnt_reg[0];
    assign edge_cnt     = edge_poly_reg ? cnt_reg[1] : cnt_reg[0];
    assign edge_inc     = CNT_W'(edge_idx_reg) + CNT_W'(1);
    assign edge_wrap    = (edge_inc == edge_cnt);
    assign edge_nxt_idx = edge_wrap ? '0 : edge_inc[IDX_W-1:0];
    assign proj_cnt     = proj_poly_reg ? cnt_reg[1] : cnt_reg[0];
    assign proj_inc     = CNT_W'(proj_idx_reg) + CNT_W'(1);
    assign proj_last    = (proj_inc == proj_cnt);
    assign proj         = JW'(acc_reg) - JW'(prod_reg);
    // touching intervals are not separated
    assign separated    = (hi_reg[0] < lo_reg[1]) || (hi_reg[1] < lo_reg[0]);
    assign out_free     = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign overlap   = overlap_reg;
    assign status    = status_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        ovf_next          = ovf_reg;
        edge_poly_next    = edge_poly_reg;
        edge_idx_next     = edge_idx_reg;
        proj_poly_next    = proj_poly_reg;
        proj_idx_next     = proj_idx_reg;
        xi_next           = xi_reg;
        yi_next           = yi_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        pend_overlap_next = pend_overlap_reg;
        pend_status_next  = pend_status_reg;
        out_valid_next    = out_valid_reg;
        overlap_next      = overlap_reg;
        status_next       = status_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        addr_poly         = 1'b0;
        addr_idx          = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                addr_poly = polygon_select;
                addr_idx  = sel_cnt[IDX_W-1:0];
                if (in_valid)
                begin
                    // store the vertex, or drop it when its polygon is full
                    if (sel_cnt < CNT_W'(MAX_VERTS))
                    begin
                        ram_we                           = 1'b1;
                        cnt_next[int'(polygon_select)] = sel_cnt + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_vertex)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                pend_overlap_next = 1'b0;
                if (ovf_reg)
                begin
                    pend_status_next = cpos_pkg::STATUS_OVERFLOW;
                    state_next       = S_EMIT;
                end
                else if (cnt_reg[0] == '0 || cnt_reg[1] == '0)
                begin
                    pend_status_next = cpos_pkg::STATUS_EMPTY;
                    state_next       = S_EMIT;
                end
                else
                begin
                    pend_status_next = cpos_pkg::STATUS_OK;
                    edge_poly_next   = 1'b0;
                    edge_idx_next    = '0;
                    state_next       = S_EDGE_RD0;
                end
            end

            S_EDGE_RD0:
            begin
                ram_re     = 1'b1;
                addr_poly  = edge_poly_reg;
                addr_idx   = edge_idx_reg;
                state_next = S_EDGE_RD1;
            end

            S_EDGE_RD1:
            begin
                // start vertex arrives, read the end vertex
                ram_re     = 1'b1;
                addr_poly  = edge_poly_reg;
                addr_idx   = edge_nxt_idx;
                xi_next    = rd_x;
                yi_next    = rd_y;
                state_next = S_EDGE_D;
            end

            S_EDGE_D:
            begin
                dx_next        = DW'(rd_x) - DW'(xi_reg);
                dy_next        = DW'(rd_y) - DW'(yi_reg);
                proj_poly_next = 1'b0;
                proj_idx_next  = '0;
                state_next     = S_P_RD;
            end

            S_P_RD:
            begin
                ram_re     = 1'b1;
                addr_poly  = proj_poly_reg;
                addr_idx   = proj_idx_reg;
                state_next = S_P_M1;
            end

            S_P_M1:
            begin
                prod_next  = mul_res;
                state_next = S_P_M2;
            end

            S_P_M2:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_res;
                state_next = S_P_UPD;
            end

            S_P_UPD:
            begin
                // each interval starts from its first projection
                if (proj_idx_reg == '0 || proj < lo_reg[int'(proj_poly_reg)])
                begin
                    lo_next[int'(proj_poly_reg)] = proj;
                end
                if (proj_idx_reg == '0 || proj > hi_reg[int'(proj_poly_reg)])
                begin
                    hi_next[int'(proj_poly_reg)] = proj;
                end
                if (proj_last)
                begin
                    if (!proj_poly_reg)
                    begin
                        proj_poly_next = 1'b1;
                        proj_idx_next  = '0;
                        state_next     = S_P_RD;
                    end
                    else
                    begin
                        state_next = S_CMP;
                    end
                end
                else
                begin
                    proj_idx_next = proj_inc[IDX_W-1:0];
                    state_next    = S_P_RD;
                end
            end

            S_CMP:
            begin
                if (separated)
                begin
                    pend_overlap_next = 1'b0;
                    state_next        = S_EMIT;
                end
                else if (edge_wrap)
                begin
                    if (!edge_poly_reg)
                    begin
                        edge_poly_next = 1'b1;
                        edge_idx_next  = '0;
                        state_next     = S_EDGE_RD0;
                    end
                    else
                    begin
                        // no axis of either polygon separates them
                        pend_overlap_next = 1'b1;
                        state_next        = S_EMIT;
                    end
                end
                else
                begin
                    edge_idx_next = edge_inc[IDX_W-1:0];
                    state_next    = S_EDGE_RD0;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    overlap_next   = pend_overlap_reg;
                    status_next    = pend_status_reg;
                    cnt_next[0]    = '0;
                    cnt_next[1]    = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg[0]       <= '0;
            cnt_reg[1]       <= '0;
            ovf_reg          <= 1'b0;
            edge_poly_reg    <= 1'b0;
            edge_idx_reg     <= '0;
            proj_poly_reg    <= 1'b0;
            proj_idx_reg     <= '0;
            xi_reg           <= '0;
            yi_reg           <= '0;
            dx_reg           <= '0;
            dy_reg           <= '0;
            prod_reg         <= '0;
            acc_reg          <= '0;
            lo_reg[0]        <= '0;
            lo_reg[1]        <= '0;
            hi_reg[0]        <= '0;
            hi_reg[1]        <= '0;
            pend_overlap_reg <= 1'b0;
            pend_status_reg  <= cpos_pkg::STATUS_OK;
            out_valid_reg    <= 1'b0;
            overlap_reg      <= 1'b0;
            status_reg       <= cpos_pkg::STATUS_OK;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            ovf_reg          <= ovf_next;
            edge_poly_reg    <= edge_poly_next;
            edge_idx_reg     <= edge_idx_next;
            proj_poly_reg    <= proj_poly_next;
            proj_idx_reg     <= proj_idx_next;
            xi_reg           <= xi_next;
            yi_reg           <= yi_next;
            dx_reg           <= dx_next;
            dy_reg           <= dy_next;
            prod_reg         <= prod_next;
            acc_reg          <= acc_next;
            lo_reg           <= lo_next;
            hi_reg           <= hi_next;
            pend_overlap_reg <= pend_overlap_next;
            pend_status_reg  <= pend_status_next;
            out_valid_reg    <= out_valid_next;
            overlap_reg      <= overlap_next;
            status_reg       <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cpos_checker.sv =====
`default_nettype none

module cpos_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       last_vertex,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       overlap,
    input wire logic [1:0] status
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(overlap) && $stable(status))
        else $error("result changed while stalled");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == cpos_pkg::STATUS_OK || status == cpos_pkg::STATUS_OVERFLOW
                       || status == cpos_pkg::STATUS_EMPTY))
        else $error("undefined status code");

    // an error status never reports overlap
    a_err_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != cpos_pkg::STATUS_OK |-> !overlap)
        else $error("overlap set with error status");

    // the block is busy right after taking the closing vertex
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_vertex |=> !in_ready)
        else $error("ready right after closing vertex");

endmodule

bind convex_polygon_overlap_sat_core cpos_checker u_cpos_checker (.*);

`default_nettype wire
